// ----- src/mm4_pkg.sv -----
// Shared constants, types and helpers for the 4x4 fixed-point matrix multiplier.
`timescale 1ns / 1ps

package mm4_pkg;

  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = 4;
  localparam int K_W        = 2;
  localparam int PROD_W     = 2 * VALUE_BITS;
  localparam int ACC_W      = PROD_W + 2;
  localparam int CELLS      = 16;

  localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(CELLS - 1);
  localparam logic [K_W-1:0]   K_LAST     = '1;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic signed [DATA_W-1:0] data_t;

  // Only the low VALUE_BITS bits of a stored element take part.
  function automatic logic signed [VALUE_BITS-1:0] narrow(data_t raw);
    return raw[VALUE_BITS-1:0];
  endfunction

endpackage

// ----- src/mm4_in_if.sv -----
// Load channel: element index plus left and right matrix elements.
`timescale 1ns / 1ps

interface mm4_in_if;
  logic                        valid;
  logic                        ready;
  logic [3:0]                  elem_index;
  logic signed [31:0]          left_value;
  logic signed [31:0]          right_value;

  modport source (output valid, output elem_index, output left_value, output right_value,
                  input ready);
  modport sink   (input valid, input elem_index, input left_value, input right_value,
                  output ready);
endinterface

// ----- src/mm4_out_if.sv -----
// Result channel: one product element per transfer.
`timescale 1ns / 1ps

interface mm4_out_if;
  logic                        valid;
  logic                        ready;
  logic [3:0]                  out_index;
  logic signed [31:0]          out_value;
  logic                        saturated;
  logic                        last;

  modport source (output valid, output out_index, output out_value, output saturated,
                  output last, input ready);
  modport sink   (input valid, input out_index, input out_value, input saturated,
                  input last, output ready);
endinterface

// ----- src/matrix_multiply_4x4.sv -----
// 4x4 signed fixed-point matrix multiplier with element stores and one shared MAC.
//
// Usage:
//   in_ch  : each transfer writes left and right element elem_index (row*4+col)
//            into two 16-entry stores. A transfer with index 15 writes its
//            elements and then starts the product of the stored matrices.
//   out_ch : sixteen results in row-major order; last marks index 15.
//            Each is the 4-term dot product shifted right by FRAC_BITS and
//            saturated to VALUE_BITS, with saturated set when clipped.
// Timing: one load per cycle while idle; in_ch.ready is low while the 64
//   multiply-accumulates are issued. Elements are computed one at a time:
//   the four terms of an element issue back to back, and the next element
//   waits until the MAC pipeline is empty and the output register is free.
//   Each store has a single read port and the one multiplier is shared, four reads per element.
// Reset: both stores read as zero until written; no results pending.
// Stall: a result waits in the output register; the next element is not
//   issued until that register is free, so nothing is dropped.
`timescale 1ns / 1ps

module matrix_multiply_4x4 (
  input  logic       clk,
  input  logic       rst_n,
  mm4_in_if.sink     in_ch,
  mm4_out_if.source  out_ch
);
  import mm4_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t            state_r;
  idx_t              e_r;
  logic [K_W-1:0]    k_r;

  data_t             left_mem  [CELLS];
  data_t             right_mem [CELLS];
  logic [CELLS-1:0]  vld_r;

  logic              in_xfer;
  logic              inflight;
  logic              issue;
  idx_t              la;
  idx_t              ra;

  logic              rd_v_r, rd_first_r, rd_fin_r;
  idx_t              rd_idx_r;
  data_t             rd_left_r, rd_right_r;

  logic              prod_v_r, prod_first_r, prod_fin_r;
  idx_t              prod_idx_r;
  logic signed [PROD_W-1:0] prod_r;

  logic signed [ACC_W-1:0]  acc_r;
  logic              done_v_r;
  idx_t              done_idx_r;

  logic signed [ACC_W-1:0]      acc_sh;
  logic signed [VALUE_BITS-1:0] res_nxt;
  logic                         sat_nxt;

  logic              out_valid_r;
  idx_t              out_index_r;
  data_t             out_value_r;
  logic              sat_r;
  logic              last_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign inflight = rd_v_r || prod_v_r || done_v_r;
  assign issue    = (state_r == ST_RUN) &&
                    ((k_r != '0) || (!inflight && (!out_valid_r || out_ch.ready)));

  // left[row][k], right[k][col]
  assign la = {e_r[3:2], k_r};
  assign ra = {k_r, e_r[1:0]};

  // element stores
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      left_mem[in_ch.elem_index]  <= in_ch.left_value;
      right_mem[in_ch.elem_index] <= in_ch.right_value;
    end
    if (issue) begin
      rd_left_r  <= vld_r[la] ? left_mem[la]  : '0;
      rd_right_r <= vld_r[ra] ? right_mem[ra] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (in_xfer) begin
      vld_r[in_ch.elem_index] <= 1'b1;
    end
  end

  // MAC pipeline: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
      done_v_r <= 1'b0;
    end else begin
      rd_v_r   <= issue;
      prod_v_r <= rd_v_r;
      done_v_r <= prod_v_r && prod_fin_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r   <= (k_r == '0);
    rd_fin_r     <= (k_r == K_LAST);
    rd_idx_r     <= e_r;
    prod_first_r <= rd_first_r;
    prod_fin_r   <= rd_fin_r;
    prod_idx_r   <= rd_idx_r;
    prod_r       <= narrow(rd_left_r) * narrow(rd_right_r);
    done_idx_r   <= prod_idx_r;
    if (prod_v_r) begin
      acc_r <= (prod_first_r ? ACC_W'(0) : acc_r) + ACC_W'(prod_r);
    end
  end

  // floor shift and saturation
  always_comb begin
    acc_sh = acc_r >>> FRAC_BITS;
    if ((&acc_sh[ACC_W-1:VALUE_BITS-1]) || !(|acc_sh[ACC_W-1:VALUE_BITS-1])) begin
      res_nxt = acc_sh[VALUE_BITS-1:0];
      sat_nxt = 1'b0;
    end else if (acc_sh[ACC_W-1]) begin
      res_nxt = {1'b1, {(VALUE_BITS-1){1'b0}}};
      sat_nxt = 1'b1;
    end else begin
      res_nxt = {1'b0, {(VALUE_BITS-1){1'b1}}};
      sat_nxt = 1'b1;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      e_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      out_index_r <= '0;
      out_value_r <= '0;
      sat_r       <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer && (in_ch.elem_index == LAST_INDEX)) begin
            state_r <= ST_RUN;
            e_r     <= '0;
            k_r     <= '0;
          end
        end
        ST_RUN: begin
          if (issue) begin
            k_r <= k_r + 1'b1;
            if (k_r == K_LAST) begin
              e_r <= e_r + 1'b1;
              if (e_r == LAST_INDEX) begin
                state_r <= ST_IDLE;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (done_v_r) begin
        out_valid_r <= 1'b1;
        out_index_r <= done_idx_r;
        out_value_r <= DATA_W'(res_nxt);
        sat_r       <= sat_nxt;
        last_r      <= (done_idx_r == LAST_INDEX);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_index = out_index_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.saturated = sat_r;
  assign out_ch.last      = last_r;

  // a finished element never lands on an unread result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    done_v_r |-> !out_valid_r)
    else $error("result register overwritten");

  // the four products of an element reach the accumulator back to back
  a_mac_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (prod_v_r && !prod_first_r) |-> $past(prod_v_r))
    else $error("gap inside dot product");

  // a start transfer begins at element 0, term 0
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_ch.elem_index == LAST_INDEX)) |=>
      (state_r == ST_RUN) && (e_r == '0) && (k_r == '0))
    else $error("product did not start cleanly");

  // the marked result is the final element
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> (out_index_r == LAST_INDEX))
    else $error("last flag on wrong element");

endmodule

// ----- bench/matrix_multiply_4x4_tb.sv -----
// Self-checking testbench for the 4x4 fixed-point matrix multiplier.
`timescale 1ns / 1ps

module matrix_multiply_4x4_tb;
  import mm4_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_TIME  = 150;
  localparam int SUM_W        = 2 * VALUE_BITS + 2;
  localparam data_t VAL_MAX   = 32'sh7FFF_FFFF;
  localparam data_t VAL_MIN   = 32'sh8000_0000;
  localparam data_t ONE_Q     = 32'sh0001_0000;

  typedef struct {
    idx_t  index;
    data_t left;
    data_t right;
  } load_t;

  typedef struct {
    idx_t  index;
    data_t value;
    logic  saturated;
    logic  last;
  } product_elem_t;

  logic clk;
  logic rst_n;

  mm4_in_if  load_bus ();
  mm4_out_if product_bus ();

  matrix_multiply_4x4 i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (load_bus),
    .out_ch (product_bus)
  );

  load_t         load_queue[$];
  product_elem_t expected_elems[$];
  data_t         left_mirror[CELLS];
  data_t         right_mirror[CELLS];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  bit pressure_on        = 0;
  int hold_count         = 0;
  int loads_offered      = 0;
  int loads_taken        = 0;
  int products_started   = 0;
  int elems_checked      = 0;
  int sat_seen           = 0;
  int error_count        = 0;
  int cycle_count        = 0;

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the stores; an index-15 transfer yields all sixteen product elements.
  function automatic void predict_product();
    logic signed [VALUE_BITS-1:0] a;
    logic signed [VALUE_BITS-1:0] b;
    logic signed [SUM_W-1:0]      acc;
    logic signed [SUM_W-1:0]      shifted;
    logic signed [SUM_W-1:0]      hi_lim;
    logic signed [SUM_W-1:0]      lo_lim;
    product_elem_t                elem;
    hi_lim = {{(SUM_W-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
    lo_lim = -hi_lim - 1;
    for (int k = 0; k < CELLS; k++) begin
      acc = '0;
      for (int j = 0; j < 4; j++) begin
        a = left_mirror[(k / 4) * 4 + j][VALUE_BITS-1:0];
        b = right_mirror[j * 4 + (k % 4)][VALUE_BITS-1:0];
        acc += a * b;
      end
      shifted = acc >>> FRAC_BITS;
      elem.saturated = 1'b0;
      if (shifted > hi_lim) begin
        shifted = hi_lim;
        elem.saturated = 1'b1;
      end else if (shifted < lo_lim) begin
        shifted = lo_lim;
        elem.saturated = 1'b1;
      end
      elem.index = idx_t'(k);
      elem.value = shifted[DATA_W-1:0];
      elem.last  = (idx_t'(k) == LAST_INDEX);
      expected_elems.push_back(elem);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && load_bus.valid && load_bus.ready) begin
      loads_taken++;
      left_mirror[load_bus.elem_index]  = load_bus.left_value;
      right_mirror[load_bus.elem_index] = load_bus.right_value;
      if (load_bus.elem_index == LAST_INDEX) begin
        products_started++;
        predict_product();
      end
    end
  end

  always @(posedge clk) begin
    product_elem_t exp_elem;
    if (rst_n && product_bus.valid && product_bus.ready) begin
      if (expected_elems.size() == 0) begin
        $error("unexpected product transfer: index %0d value %0h",
               product_bus.out_index, product_bus.out_value);
        error_count++;
      end else begin
        exp_elem = expected_elems.pop_front();
        elems_checked++;
        if (product_bus.saturated) sat_seen++;
        if (product_bus.out_index !== exp_elem.index) begin
          $error("out_index: expected %0d, got %0d", exp_elem.index, product_bus.out_index);
          error_count++;
        end
        if (product_bus.out_value !== exp_elem.value) begin
          $error("out_value: expected %0h, got %0h", exp_elem.value, product_bus.out_value);
          error_count++;
        end
        if (product_bus.saturated !== exp_elem.saturated) begin
          $error("saturated: expected %0b, got %0b", exp_elem.saturated,
                 product_bus.saturated);
          error_count++;
        end
        if (product_bus.last !== exp_elem.last) begin
          $error("last: expected %0b, got %0b", exp_elem.last, product_bus.last);
          error_count++;
        end
      end
    end
  end

  // Load driver
  always @(negedge clk) begin
    load_t item;
    if (rst_n) begin
      if (load_bus.valid && loads_taken != loads_offered) begin
        // transfer still pending, hold
      end else if (load_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        item = load_queue.pop_front();
        load_bus.valid       <= 1'b1;
        load_bus.elem_index  <= item.index;
        load_bus.left_value  <= item.left;
        load_bus.right_value <= item.right;
        loads_offered++;
      end else begin
        load_bus.valid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off under pressure
  always @(negedge clk) begin
    if (pressure_on && hold_count < HOLD_CYCLES) begin
      product_bus.ready <= 1'b0;
      hold_count++;
    end else begin
      product_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic data_t rand_element();
    case ($urandom_range(0, 7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return -1;
      4, 5:    return data_t'($urandom_range(0, 1 << 19)) - (1 << 18);
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic push_load(int index, data_t left, data_t right);
    load_t item;
    item.index = idx_t'(index);
    item.left  = left;
    item.right = right;
    load_queue.push_back(item);
  endtask

  task automatic push_sequence();
    for (int i = 0; i < CELLS; i++) push_load(i, rand_element(), rand_element());
  endtask

  // Mostly complete matrices, plus truncated sequences and stray writes.
  task automatic push_random_loads(int count);
    int added;
    int cut;
    int pick;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        push_sequence();
        added += CELLS;
      end else if (pick < 8) begin
        cut = $urandom_range(1, 14);
        for (int i = 0; i < cut; i++) push_load(i, rand_element(), rand_element());
        added += cut;
        if ($urandom_range(0, 1)) begin
          push_load(CELLS - 1, rand_element(), rand_element());
          added++;
        end
      end else begin
        push_load($urandom_range(0, CELLS - 1), rand_element(), rand_element());
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    while (load_queue.size() > 0 || loads_taken != loads_offered ||
           expected_elems.size() > 0)
      @(negedge clk);
  endtask

  initial begin
    int idle_pct[4];
    int stall_pct[4];
    idle_pct  = '{0, 81, 0, 27};
    stall_pct = '{0, 0, 81, 27};
    rst_n                   = 1'b0;
    load_bus.valid          = 1'b0;
    load_bus.elem_index     = '0;
    load_bus.left_value     = '0;
    load_bus.right_value    = '0;
    product_bus.ready       = 1'b0;
    for (int i = 0; i < CELLS; i++) begin
      left_mirror[i]  = '0;
      right_mirror[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes against cleared stores, floor rounding, repeated start,
    // then identity times a known matrix.
    push_load(15, VAL_MAX, VAL_MAX);
    push_load(15, VAL_MIN, VAL_MIN);
    push_load(15, VAL_MIN, VAL_MAX);
    push_load(15, -1, 1);
    for (int i = 0; i < CELLS - 1; i++)
      push_load(i, (i % 5 == 0) ? ONE_Q : data_t'(0),
                (i % 2) ? -(data_t'(i) <<< 16) : (data_t'(i) <<< 16));
    push_load(15, ONE_Q, -ONE_Q);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      sender_idle_pct    = idle_pct[p];
      receiver_stall_pct = stall_pct[p];
      push_random_loads(8);
      wait_drained();
    end

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    pressure_on        = 1'b1;
    push_sequence();
    for (int i = 0; i < 8; i++) push_load(i, rand_element(), rand_element());
    wait_drained();

    repeat (SETTLE_TIME) @(negedge clk);

    $display("Covered %0d load transfers and %0d products; %0d elements checked, %0d saturated.",
             loads_taken, products_started, elems_checked, sat_seen);
    $display("Idle mixes on both channels plus a %0d-cycle output hold-off.", HOLD_CYCLES);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
